[rtl/core/urrb_pkg.sv]
// Package for the UART receive/transmit ring buffer engine.
// Holds request codes, the request/response structs and the control command struct.
// No dependencies.
`default_nettype none

package urrb_pkg;

  // Default ring depth in bytes.
  localparam int RING_DEPTH_DEF = 64;

  // Request codes.
  localparam logic [1:0] REQ_PUT     = 2'd0;
  localparam logic [1:0] REQ_GET     = 2'd1;
  localparam logic [1:0] REQ_SERVICE = 2'd2;

  // One request.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] send_byte;
    logic       line_data_ready;
    logic       line_tx_empty;
    logic       line_overrun;
    logic [7:0] incoming_byte;
  } req_t;

  // One response.
  typedef struct packed {
    logic [7:0] got_byte;
    logic       got_valid;
    logic [7:0] transmit_byte;
    logic       transmit_valid;
    logic       would_block;
    logic       overrun_error;
    logic       rx_irq_enable;
    logic       tx_irq_enable;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the request
    logic exec;     // update rings, pointers and enables
    logic present;  // drive the response this cycle
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/uart_rx_tx_ring_buffer_engine.sv]
// Top level of the UART receive/transmit ring buffer engine.
// Instantiates urrb_ctrl and urrb_dpath; depends on urrb_pkg.
//
//   channel   handshake          payload   direction
//   request   start_i / busy_o   req_i     in
//   response  done_o strobe      rsp_o     out
//
// Each request passes through capture, execute (ring memory write or
// registered read, pointer update), then done_o high for one cycle.
// busy_o is high from the cycle after acceptance through the done_o cycle.
// The response is shown for exactly one cycle and cannot be stalled.
// Reset clears pointers, sets the receive enable and clears the transmit
// enable; ring contents are not cleared, no clearing pass is needed.
`default_nettype none

module uart_rx_tx_ring_buffer_engine #(
  parameter int RING_DEPTH = urrb_pkg::RING_DEPTH_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  urrb_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            done_o,
  output urrb_pkg::rsp_t  rsp_o
);
  import urrb_pkg::*;

  cmd_t cmd;

  urrb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  urrb_dpath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dpath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .req_i (req_i),
    .rsp_o (rsp_o)
  );

  assign done_o = cmd.present;

endmodule

`default_nettype wire

[rtl/core/urrb_ctrl.sv]
// Controller for the ring buffer engine: sequences load, execute and respond.
// Depends on urrb_pkg for the command struct.
`default_nettype none

module urrb_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  output logic            busy_o,
  output urrb_pkg::cmd_t  cmd_o
);
  import urrb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands and status
  assign busy_o        = (state_q != ST_IDLE);
  assign cmd_o.load    = (state_q == ST_IDLE) && start_i;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.present = (state_q == ST_DONE);

endmodule

`default_nettype wire

[rtl/core/urrb_dpath.sv]
// Datapath for the ring buffer engine: both byte rings, their pointers,
// the interrupt enable bits and the response register. Depends on urrb_pkg.
`default_nettype none

module urrb_dpath #(
  parameter int RING_DEPTH = urrb_pkg::RING_DEPTH_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  urrb_pkg::cmd_t  cmd_i,
  input  urrb_pkg::req_t  req_i,
  output urrb_pkg::rsp_t  rsp_o
);
  import urrb_pkg::*;

  localparam int PTR_W = $clog2(2 * RING_DEPTH);
  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PTR_W-1:0] DepthP = PTR_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0] LastP  = PTR_W'(2 * RING_DEPTH - 1);
  localparam logic [PTR_W:0]   SpanP  = (PTR_W + 1)'(2 * RING_DEPTH);

  // Pointer helpers: pointers run modulo twice the depth.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LastP) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p >= DepthP) ? p - DepthP : p;
    return r[IDX_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_cnt(input logic [PTR_W-1:0] tl,
                                               input logic [PTR_W-1:0] hd);
    logic [PTR_W:0] diff;
    diff = {1'b0, tl} - {1'b0, hd};
    if (diff[PTR_W]) diff = diff + SpanP;
    return diff[PTR_W-1:0];
  endfunction

  req_t             req_q;
  logic [PTR_W-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
  logic             rx_en_q, tx_en_q;
  logic             got_v_q, tx_v_q, blk_q, ovr_q;
  logic [7:0]       rx_rd_q, tx_rd_q;
  logic [7:0]       rx_mem [RING_DEPTH];
  logic [7:0]       tx_mem [RING_DEPTH];

  logic [PTR_W-1:0] rx_cnt, tx_cnt;
  logic             rx_full, rx_empty, tx_full, tx_empty;
  logic             is_put, is_get, is_svc;
  logic             rx_push, rx_pop, tx_push, tx_pop;
  logic             blk_d, ovr_d;

  // Ring occupancy
  assign rx_cnt   = ptr_cnt(rx_tail_q, rx_head_q);
  assign tx_cnt   = ptr_cnt(tx_tail_q, tx_head_q);
  assign rx_full  = (rx_cnt >= DepthP);
  assign tx_full  = (tx_cnt >= DepthP);
  assign rx_empty = (rx_cnt == '0);
  assign tx_empty = (tx_cnt == '0);

  // Decode of the captured request
  assign is_put = cmd_i.exec && (req_q.req_type == REQ_PUT);
  assign is_get = cmd_i.exec && (req_q.req_type == REQ_GET);
  assign is_svc = cmd_i.exec && (req_q.req_type == REQ_SERVICE) && !req_q.line_overrun;

  assign tx_push = is_put && !tx_full;
  assign rx_pop  = is_get && !rx_empty;
  assign rx_push = is_svc && req_q.line_data_ready && !rx_full;
  assign tx_pop  = is_svc && req_q.line_tx_empty && !tx_empty;
  assign blk_d   = (is_put && tx_full) || (is_get && rx_empty);
  assign ovr_d   = cmd_i.exec && (req_q.req_type == REQ_SERVICE) && req_q.line_overrun;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  // Pointers and interrupt enables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      rx_en_q   <= 1'b1;
      tx_en_q   <= 1'b0;
    end else begin
      if (rx_push) rx_tail_q <= ptr_inc(rx_tail_q);
      if (rx_pop)  rx_head_q <= ptr_inc(rx_head_q);
      if (tx_push) tx_tail_q <= ptr_inc(tx_tail_q);
      if (tx_pop)  tx_head_q <= ptr_inc(tx_head_q);
      if (rx_pop) begin
        rx_en_q <= 1'b1;
      end else if (is_svc && req_q.line_data_ready && rx_full) begin
        rx_en_q <= 1'b0;
      end
      if (tx_push) begin
        tx_en_q <= 1'b1;
      end else if (is_svc && req_q.line_tx_empty && tx_empty) begin
        tx_en_q <= 1'b0;
      end
    end
  end

  // Receive ring storage
  always_ff @(posedge clk_i) begin
    if (rx_push) rx_mem[ptr_idx(rx_tail_q)] <= req_q.incoming_byte;
    if (rx_pop)  rx_rd_q <= rx_mem[ptr_idx(rx_head_q)];
  end

  // Transmit ring storage
  always_ff @(posedge clk_i) begin
    if (tx_push) tx_mem[ptr_idx(tx_tail_q)] <= req_q.send_byte;
    if (tx_pop)  tx_rd_q <= tx_mem[ptr_idx(tx_head_q)];
  end

  // Result flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      got_v_q <= rx_pop;
      tx_v_q  <= tx_pop;
      blk_q   <= blk_d;
      ovr_q   <= ovr_d;
    end
  end

  // Response
  assign rsp_o.got_byte       = got_v_q ? rx_rd_q : 8'd0;
  assign rsp_o.got_valid      = got_v_q;
  assign rsp_o.transmit_byte  = tx_v_q ? tx_rd_q : 8'd0;
  assign rsp_o.transmit_valid = tx_v_q;
  assign rsp_o.would_block    = blk_q;
  assign rsp_o.overrun_error  = ovr_q;
  assign rsp_o.rx_irq_enable  = rx_en_q;
  assign rsp_o.tx_irq_enable  = tx_en_q;

  // Checks
  a_rx_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt <= DepthP) else $error("rx ring count beyond depth");
  a_tx_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_cnt <= DepthP) else $error("tx ring count beyond depth");
  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(rx_head_q) && $stable(rx_tail_q) &&
                    $stable(tx_head_q) && $stable(tx_tail_q))
    else $error("ring pointer moved outside execute");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.present |-> !(rsp_o.would_block && (rsp_o.got_valid || rsp_o.transmit_valid)))
    else $error("would_block together with a data transfer");

endmodule

`default_nettype wire

[bench/tb_uart_rx_tx_ring_buffer_engine.sv]
// Self-checking bench for the UART ring buffer engine: put, get and service requests
// against a cycle-free ring model. Depends on urrb_pkg and uart_rx_tx_ring_buffer_engine.
`timescale 1ns / 100ps

module tb_uart_rx_tx_ring_buffer_engine;
  import urrb_pkg::*;

  localparam int DEPTH = RING_DEPTH_DEF;
  localparam int PTR_W = $clog2(DEPTH) + 1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1030;
  localparam int QUIET_LIMIT = 1000;
  localparam int PH_FILL = 0;
  localparam int PH_DRAIN = 1;
  localparam int PH_MIXED = 2;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct {
    req_t req;
    bit   drain_first;  // hold off until every response is back
    bit   gap_ok;       // idle bursts allowed after this transfer
  } pending_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  pending_t pending_q[$];
  rsp_t     ring_rsp_q[$];
  int       err_count = 0;
  int       quiet_cycles = 0;
  int       gap_left = 0;
  bit       cur_gap_ok = 1'b0;

  // Ring model state
  logic [7:0] rx_mem[DEPTH];
  logic [7:0] tx_mem[DEPTH];
  ptr_t rx_rd = '0, rx_wr = '0, tx_rd = '0, tx_wr = '0;
  logic rx_en = 1'b1, tx_en = 1'b0;

  uart_rx_tx_ring_buffer_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the ring model and return the response it gives
  function automatic rsp_t next_ring_response(req_t r);
    rsp_t o;
    o = '0;
    case (r.req_type)
      REQ_PUT: begin
        if (ptr_t'(tx_wr - tx_rd) == ptr_t'(DEPTH)) begin
          o.would_block = 1'b1;
        end else begin
          tx_mem[tx_wr[PTR_W-2:0]] = r.send_byte;
          tx_wr = tx_wr + 1'b1;
          tx_en = 1'b1;
        end
      end
      REQ_GET: begin
        if (rx_wr == rx_rd) begin
          o.would_block = 1'b1;
        end else begin
          o.got_byte = rx_mem[rx_rd[PTR_W-2:0]];
          o.got_valid = 1'b1;
          rx_rd = rx_rd + 1'b1;
          rx_en = 1'b1;
        end
      end
      REQ_SERVICE: begin
        if (r.line_overrun) begin
          o.overrun_error = 1'b1;
        end else begin
          // receive side: store the byte, or mask the interrupt when full
          if (r.line_data_ready) begin
            if (ptr_t'(rx_wr - rx_rd) != ptr_t'(DEPTH)) begin
              rx_mem[rx_wr[PTR_W-2:0]] = r.incoming_byte;
              rx_wr = rx_wr + 1'b1;
            end else begin
              rx_en = 1'b0;
            end
          end
          // transmit side: pop one byte, or mask the interrupt when empty
          if (r.line_tx_empty) begin
            if (tx_wr != tx_rd) begin
              o.transmit_byte = tx_mem[tx_rd[PTR_W-2:0]];
              o.transmit_valid = 1'b1;
              tx_rd = tx_rd + 1'b1;
            end else begin
              tx_en = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    o.rx_irq_enable = rx_en;
    o.tx_irq_enable = tx_en;
    return o;
  endfunction

  task automatic queue_request(input logic [1:0] kind, input logic [7:0] sbyte,
                               input bit dr, input bit thre, input bit ovr,
                               input logic [7:0] ibyte, input bit drain_first,
                               input bit gap_ok);
    pending_t p;
    p.req.req_type = kind;
    p.req.send_byte = sbyte;
    p.req.line_data_ready = dr;
    p.req.line_tx_empty = thre;
    p.req.line_overrun = ovr;
    p.req.incoming_byte = ibyte;
    p.drain_first = drain_first;
    p.gap_ok = gap_ok;
    pending_q.push_back(p);
  endtask

  // Request driver: predicts on each transfer, then presents the next item
  always @(posedge clk_i) begin : drive
    bit accepted;
    bit drained;
    pending_t nxt;
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      if (accepted) begin
        ring_rsp_q.push_back(next_ring_response(req_i));
        if (cur_gap_ok && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 4);
      end
      // order-independent view of whether the monitor has emptied the queue
      drained = (ring_rsp_q.size() == 0) || (ring_rsp_q.size() == 1 && done_o);
      if (start_i && !accepted) begin
        // keep holding the current request
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_q.size() > 0 && (!pending_q[0].drain_first || drained)) begin
        nxt = pending_q.pop_front();
        cur_gap_ok = nxt.gap_ok;
        req_i <= nxt.req;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Response monitor and progress counter
  always @(posedge clk_i) begin : check
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (ring_rsp_q.size() == 0) begin
          err_count <= err_count + 1;
          $display("%0t: unexpected response %h, none pending", $time, rsp_o);
        end else begin
          want = ring_rsp_q.pop_front();
          if (rsp_o !== want) begin
            err_count <= err_count + 1;
            $display("%0t: mismatch exp got=%h/%b tx=%h/%b blk=%b ovr=%b rxie=%b txie=%b",
                     $time, want.got_byte, want.got_valid, want.transmit_byte,
                     want.transmit_valid, want.would_block, want.overrun_error,
                     want.rx_irq_enable, want.tx_irq_enable);
            $display("%0t:          act got=%h/%b tx=%h/%b blk=%b ovr=%b rxie=%b txie=%b",
                     $time, rsp_o.got_byte, rsp_o.got_valid, rsp_o.transmit_byte,
                     rsp_o.transmit_valid, rsp_o.would_block, rsp_o.overrun_error,
                     rsp_o.rx_irq_enable, rsp_o.tx_irq_enable);
          end
        end
      end
      if (done_o || (start_i && !busy_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("uart_rx_tx_ring_buffer_engine test failed");
    $finish;
  end

  // Stimulus and end of test
  initial begin : stim
    int n;
    int i;
    int kind;
    int len;
    int roll;
    int put_pct, get_pct, svc_pct, dr_pct, thre_pct;
    logic [1:0] rt;

    // directed: empty get, overrun, empty and non-empty pops, unused code
    queue_request(REQ_GET, 8'h00, 0, 0, 0, 8'h00, 0, 1);
    queue_request(REQ_SERVICE, 8'h00, 0, 1, 0, 8'h00, 0, 1);
    queue_request(REQ_PUT, 8'h00, 0, 0, 0, 8'h00, 0, 1);
    queue_request(REQ_PUT, 8'hFF, 1, 1, 1, 8'hFF, 0, 1);
    queue_request(REQ_SERVICE, 8'h00, 1, 1, 1, 8'hAA, 0, 1);
    queue_request(REQ_SERVICE, 8'h00, 1, 1, 0, 8'hFF, 0, 1);
    queue_request(REQ_GET, 8'h00, 0, 0, 0, 8'h00, 0, 1);
    queue_request(REQ_GET, 8'hFF, 1, 1, 1, 8'hFF, 0, 1);
    queue_request(REQ_UNUSED, 8'hFF, 1, 1, 1, 8'hFF, 0, 1);
    queue_request(REQ_SERVICE, 8'h00, 1, 0, 0, 8'h00, 0, 1);
    queue_request(REQ_SERVICE, 8'h00, 1, 1, 0, 8'h5A, 1, 1);
    queue_request(REQ_SERVICE, 8'h00, 0, 1, 0, 8'h00, 0, 1);
    queue_request(REQ_GET, 8'h00, 0, 0, 0, 8'h00, 0, 1);
    queue_request(REQ_GET, 8'h00, 0, 0, 0, 8'h00, 0, 1);
    queue_request(REQ_PUT, 8'hA5, 0, 0, 0, 8'h00, 0, 1);
    queue_request(REQ_UNUSED, 8'h00, 0, 0, 0, 8'h00, 0, 1);

    // random phases biased toward filling or draining the rings;
    // the first one is long enough to reach both full conditions
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == 0) begin
        kind = PH_FILL;
        len = 200;
      end else begin
        kind = $urandom_range(0, 2);
        len = $urandom_range(60, 160);
      end
      case (kind)
        PH_FILL: begin
          put_pct = 40; get_pct = 5; svc_pct = 50; dr_pct = 95; thre_pct = 10;
        end
        PH_DRAIN: begin
          put_pct = 5; get_pct = 45; svc_pct = 45; dr_pct = 10; thre_pct = 90;
        end
        default: begin
          put_pct = 30; get_pct = 30; svc_pct = 35; dr_pct = 60; thre_pct = 60;
        end
      endcase
      for (i = 0; i < len && n < RANDOM_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < put_pct)
          rt = REQ_PUT;
        else if (roll < put_pct + get_pct)
          rt = REQ_GET;
        else if (roll < put_pct + get_pct + svc_pct)
          rt = REQ_SERVICE;
        else
          rt = REQ_UNUSED;
        queue_request(rt, 8'($urandom), $urandom_range(0, 99) < dr_pct,
                      $urandom_range(0, 99) < thre_pct, $urandom_range(0, 99) < 4,
                      8'($urandom), i == 0, n < RANDOM_ITEMS - 120);
        n++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start_i || ring_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (err_count == 0 && ring_rsp_q.size() == 0)
      $display("uart_rx_tx_ring_buffer_engine test passed");
    else
      $display("uart_rx_tx_ring_buffer_engine test failed");
    $finish;
  end

endmodule

[uart_rx_tx_ring_buffer_engine.f]
rtl/core/urrb_pkg.sv
rtl/core/urrb_ctrl.sv
rtl/core/urrb_dpath.sv
rtl/core/uart_rx_tx_ring_buffer_engine.sv
bench/tb_uart_rx_tx_ring_buffer_engine.sv
